// ===== rtl/tld_pkg.sv =====
// Shared types and constants of the track log delta decoder.
// Holds the packet kind codes and the controller-to-datapath command struct.
`timescale 1ns / 1ps
package tld_pkg;

  localparam logic [4:0] K_REPEAT  = 5'd0;
  localparam logic [4:0] K_D1      = 5'd1;
  localparam logic [4:0] K_D2      = 5'd2;
  localparam logic [4:0] K_D3      = 5'd3;
  localparam logic [4:0] K_D4      = 5'd4;
  localparam logic [4:0] K_D5      = 5'd5;
  localparam logic [4:0] K_D6      = 5'd6;
  localparam logic [4:0] K_D7      = 5'd7;
  localparam logic [4:0] K_D8      = 5'd8;
  localparam logic [4:0] K_D9      = 5'd9;
  localparam logic [4:0] K_D10     = 5'd10;
  localparam logic [4:0] K_ABS     = 5'd11;
  localparam logic [4:0] K_ABS_NEW = 5'd12;
  localparam logic [4:0] K_CHECK   = 5'd13;
  localparam logic [4:0] K_OPT1    = 5'd14;
  localparam logic [4:0] K_OPTN    = 5'd15;
  localparam logic [4:0] K_END     = 5'd16;

  // repeat points beyond this many are advanced but not shown
  localparam logic [6:0] MAX_SHOWN = 7'd60;

  typedef struct packed {
    logic       clear;      // block start: reset values, deltas, shift
    logic       wr_byte;    // store the input byte in the packet buffer
    logic [3:0] byte_idx;
    logic       upd_delta;  // add the gathered second differences
    logic [4:0] kind;
    logic       advance;    // values += deltas
    logic       load_abs;   // load values and shift from an absolute packet
    logic       emit;       // load the output register
    logic       new_track;
    logic       new_seg;
    logic       last;
  } tld_cmd_t;

endpackage

// ===== rtl/tld_ctrl.sv =====
// Controller of the track log delta decoder: packet framing, skips, flags
// and the point sequencer. Drives the datapath by tld_cmd_t; uses tld_pkg.
`timescale 1ns / 1ps
module tld_ctrl import tld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_block_start,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  logic       slot_free,
  output tld_cmd_t   cmd
);

  typedef enum logic [2:0] {S_IDLE, S_DELTA, S_ABS, S_ADV, S_EMIT} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] held_r, held_nxt;
  logic [8:0] skip_r, skip_nxt;
  logic [4:0] kind_r, kind_nxt;
  logic       ended_r, ended_nxt, anch_r, anch_nxt, track_r, track_nxt;
  logic       pend_r, pend_nxt, show_r, show_nxt, newtrk_r, newtrk_nxt;
  logic [6:0] cnt_r, cnt_nxt, idx_r, idx_nxt, lastix_r, lastix_nxt;
  logic [7:0] mask_r;

  function automatic logic [4:0] classify(input logic [7:0] b);
    logic [4:0] k;
    k = K_REPEAT;
    if (b[1:0] == 2'b01) k = K_D1;
    else if (b[1:0] == 2'b10) k = K_D2;
    else if (b[2:0] == 3'b011) k = K_D3;
    else if (b[4:0] == 5'h07) k = K_D4;
    else if (b[4:0] == 5'h0f) k = K_D5;
    else if (b[4:0] == 5'h17) k = K_D6;
    else if (b[6:0] == 7'h1f) k = K_D7;
    else if (b[6:0] == 7'h3f) k = K_D8;
    else if (b[6:0] == 7'h5f) k = K_D9;
    else if (b == 8'h7f) k = K_D10;
    else if (b == 8'hec) k = K_ABS;
    else if (b == 8'hf0) k = K_ABS_NEW;
    else if (b == 8'hf4) k = K_CHECK;
    else if (b == 8'hf8) k = K_OPT1;
    else if (b == 8'hfc) k = K_OPTN;
    else if (b == 8'hff) k = K_END;
    return k;
  endfunction

  function automatic logic [3:0] pkt_size(input logic [4:0] k);
    logic [3:0] s;
    case (k)
      K_D2:                   s = 4'd2;
      K_D3:                   s = 4'd3;
      K_D4, K_D5, K_D6:       s = 4'd4;
      K_D7, K_D8:             s = 4'd5;
      K_D9:                   s = 4'd6;
      K_D10:                  s = 4'd7;
      K_ABS, K_ABS_NEW:       s = 4'd15;
      K_CHECK, K_OPT1, K_OPTN: s = 4'd2;
      default:                s = 4'd1;
    endcase
    return s;
  endfunction

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    logic [3:0] eh, nh;
    logic [8:0] es;
    logic [4:0] k;
    logic [6:0] rc;
    state_nxt = state_r; held_nxt = held_r; skip_nxt = skip_r; kind_nxt = kind_r;
    ended_nxt = ended_r; anch_nxt = anch_r; track_nxt = track_r; pend_nxt = pend_r;
    show_nxt = show_r; newtrk_nxt = newtrk_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    lastix_nxt = lastix_r;
    cmd = '0;
    cmd.kind = kind_r;
    eh = 4'd0; nh = 4'd0; es = 9'd0; k = K_REPEAT; rc = 7'd0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          eh = in_block_start ? 4'd0 : held_r;
          es = in_block_start ? 9'd0 : skip_r;
          if (in_block_start) begin
            cmd.clear = 1'b1;
            held_nxt = 4'd0; skip_nxt = 9'd0; kind_nxt = K_REPEAT;
            ended_nxt = 1'b0; anch_nxt = 1'b0;
          end
          if (!in_block_start && ended_r) begin
            // drop bytes after the end marker
          end else if (es != 9'd0) begin
            skip_nxt = es - 9'd1;
          end else begin
            k = (eh == 4'd0) ? classify(in_byte) : kind_r;
            kind_nxt = k;
            cmd.wr_byte = 1'b1;
            cmd.byte_idx = eh;
            nh = eh + 4'd1;
            if (k == K_OPTN) begin
              if (nh >= 4'd2) begin
                skip_nxt = {1'b0, in_byte} + 9'd1;
                held_nxt = 4'd0;
              end else begin
                held_nxt = nh;
              end
            end else if (nh < pkt_size(k)) begin
              held_nxt = nh;
            end else begin
              held_nxt = 4'd0;
              idx_nxt = 7'd0;
              if (k == K_REPEAT) begin
                rc = {1'b0, in_byte[7:2]} + 7'd2;
                cnt_nxt = rc;
                lastix_nxt = (rc > MAX_SHOWN) ? MAX_SHOWN - 7'd1 : rc - 7'd1;
                show_nxt = track_r && anch_r && !in_block_start;
                newtrk_nxt = 1'b0;
                state_nxt = S_ADV;
              end else if (k <= K_D10) begin
                cnt_nxt = 7'd1; lastix_nxt = 7'd0;
                show_nxt = track_r && anch_r && !in_block_start;
                newtrk_nxt = 1'b0;
                state_nxt = S_DELTA;
              end else if (k == K_ABS || k == K_ABS_NEW) begin
                cnt_nxt = 7'd1; lastix_nxt = 7'd0; show_nxt = 1'b1;
                state_nxt = S_ABS;
              end else if (k == K_OPT1) begin
                if ((in_byte & mask_r) != 8'd0) pend_nxt = 1'b1;
              end else if (k == K_END) begin
                ended_nxt = 1'b1;
              end
            end
          end
        end
      end
      S_DELTA: begin
        cmd.upd_delta = 1'b1;
        state_nxt = S_ADV;
      end
      S_ABS: begin
        cmd.load_abs = 1'b1;
        anch_nxt = 1'b1;
        track_nxt = 1'b1;
        newtrk_nxt = (kind_r == K_ABS_NEW) || !track_r;
        if ((kind_r == K_ABS_NEW) || !track_r) pend_nxt = 1'b1;
        state_nxt = S_EMIT;
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        if (show_r && idx_r < MAX_SHOWN) begin
          state_nxt = S_EMIT;
        end else if (idx_r == cnt_r - 7'd1) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 7'd1;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          cmd.new_track = newtrk_r;
          cmd.new_seg = pend_r;
          cmd.last = (idx_r == lastix_r);
          pend_nxt = 1'b0;
          if (idx_r == cnt_r - 7'd1) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 7'd1;
            state_nxt = S_ADV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r <= 4'd0; skip_r <= 9'd0; kind_r <= K_REPEAT;
      ended_r <= 1'b0; anch_r <= 1'b0; track_r <= 1'b0; pend_r <= 1'b0;
      show_r <= 1'b0; newtrk_r <= 1'b0;
      cnt_r <= 7'd1; idx_r <= 7'd0; lastix_r <= 7'd0;
      mask_r <= 8'hff;
    end else begin
      state_r <= state_nxt;
      held_r <= held_nxt; skip_r <= skip_nxt; kind_r <= kind_nxt;
      ended_r <= ended_nxt; anch_r <= anch_nxt; track_r <= track_nxt; pend_r <= pend_nxt;
      show_r <= show_nxt; newtrk_r <= newtrk_nxt;
      cnt_r <= cnt_nxt; idx_r <= idx_nxt; lastix_r <= lastix_nxt;
      if (cfg_valid) mask_r <= cfg_data;
    end
  end

`ifndef SYNTH
  a_abs_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ABS) |=> (state_r == S_EMIT))
    else $error("absolute packet not followed by its point");
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV || state_r == S_EMIT) |-> (idx_r < cnt_r))
    else $error("point index past repeat count");
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != 4'hf)
    else $error("packet byte count overflow");
  a_emit_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !pend_r)
    else $error("segment flag kept after a point");
`endif

endmodule

// ===== rtl/tld_datapath.sv =====
// Datapath of the track log delta decoder: packet buffer, running values and
// differences, precision shift and the output register. Uses tld_pkg.
`timescale 1ns / 1ps
module tld_datapath import tld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tld_cmd_t     cmd,
  input  logic [7:0]   in_byte,
  output logic         slot_free,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_data,
  output logic [1:0]   out_flags,
  output logic         out_last
);

  logic [7:0]   pkt_r [15];
  logic [119:0] pk;
  logic [31:0]  val_r [4];   // lat, lon, alt, time
  logic [31:0]  dlt_r [4];
  logic [31:0]  fld [4];
  logic [2:0]   shift_r;
  logic         ovalid_r;
  logic [127:0] odata_r;
  logic [1:0]   oflags_r;
  logic         olast_r;

  always_comb begin
    for (int i = 0; i < 15; i++) pk[i*8 +: 8] = pkt_r[i];
  end

  // second differences per delta kind, order lat, lon, alt, time
  always_comb begin
    fld[0] = '0; fld[1] = '0; fld[2] = '0; fld[3] = '0;
    case (cmd.kind)
      K_D1: begin
        fld[2] = 32'($signed(pk[3:2])); fld[1] = 32'($signed(pk[5:4]));
        fld[0] = 32'($signed(pk[7:6]));
      end
      K_D2: begin
        fld[2] = 32'($signed(pk[3:2])); fld[1] = 32'($signed(pk[9:4]));
        fld[0] = 32'($signed(pk[15:10]));
      end
      K_D3: begin
        fld[2] = 32'($signed(pk[5:3])); fld[1] = 32'($signed(pk[14:6]));
        fld[0] = 32'($signed(pk[23:15]));
      end
      K_D4: begin
        fld[2] = 32'($signed(pk[7:5])); fld[1] = 32'($signed(pk[19:8]));
        fld[0] = 32'($signed(pk[31:20]));
      end
      K_D5: begin
        fld[2] = 32'($signed(pk[9:5])); fld[1] = 32'($signed(pk[20:10]));
        fld[0] = 32'($signed(pk[31:21]));
      end
      K_D6: begin
        fld[3] = 32'($signed(pk[9:5])); fld[2] = 32'($signed(pk[13:10]));
        fld[1] = 32'($signed(pk[22:14])); fld[0] = 32'($signed(pk[31:23]));
      end
      K_D7: begin
        fld[2] = 32'($signed(pk[13:7])); fld[1] = 32'($signed(pk[26:14]));
        fld[0] = 32'($signed(pk[39:27]));
      end
      K_D8: begin
        fld[3] = 32'($signed(pk[12:7])); fld[2] = 32'($signed(pk[17:13]));
        fld[1] = 32'($signed(pk[28:18])); fld[0] = 32'($signed(pk[39:29]));
      end
      K_D9: begin
        fld[2] = 32'($signed(pk[17:7])); fld[1] = 32'($signed(pk[32:18]));
        fld[0] = 32'($signed(pk[47:33]));
      end
      K_D10: begin
        fld[3] = 32'($signed(pk[14:8])); fld[2] = 32'($signed(pk[25:15]));
        fld[1] = 32'($signed(pk[40:26])); fld[0] = 32'($signed(pk[55:41]));
      end
      default: ;
    endcase
  end

  assign slot_free = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) pkt_r[cmd.byte_idx] <= in_byte;
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 4; i++) begin
        val_r[i] <= '0;
        dlt_r[i] <= '0;
      end
      dlt_r[3] <= 32'd1;
      shift_r <= 3'd0;
    end else if (cmd.upd_delta) begin
      for (int i = 0; i < 4; i++) dlt_r[i] <= dlt_r[i] + fld[i];
    end else if (cmd.advance) begin
      for (int i = 0; i < 4; i++) val_r[i] <= val_r[i] + dlt_r[i];
    end else if (cmd.load_abs) begin
      case (pk[10:8])
        3'd1:    shift_r <= 3'd3;
        3'd2:    shift_r <= 3'd5;
        3'd3:    shift_r <= 3'd7;
        default: shift_r <= 3'd0;
      endcase
      val_r[3] <= pk[42:11];
      val_r[2] <= 32'($signed(pk[58:43]));
      val_r[1] <= 32'($signed(pk[89:59]));
      val_r[0] <= 32'($signed(pk[119:90]));
      dlt_r[0] <= '0; dlt_r[1] <= '0; dlt_r[2] <= '0;
      dlt_r[3] <= 32'd1;
    end
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
    if (cmd.emit) begin
      odata_r  <= {val_r[3], val_r[2], val_r[1] << shift_r, val_r[0] << shift_r};
      oflags_r <= {cmd.new_seg, cmd.new_track};
      olast_r  <= cmd.last;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;
  assign out_flags = oflags_r;
  assign out_last  = olast_r;

`ifndef SYNTH
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("point loaded over an untaken point");
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.upd_delta, cmd.advance, cmd.load_abs}) <= 1)
    else $error("conflicting value updates");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> ovalid_r)
    else $error("emitted point not presented");
`endif

endmodule

// ===== rtl/track_log_delta_decoder_top.sv =====
// Top level of the track log delta decoder.
// Instantiates tld_ctrl and tld_datapath; uses tld_pkg.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one byte of the compressed track stream per item; in_tuser marks
//           the first byte of a new block's track area.
//   out_* : one decoded point per item; out_tlast flags the last point
//           caused by one input byte.
//   cfg_* : writes segment_mask (reset 0xFF); always ready, write while idle.
// Timing: a byte that only extends a packet or is skipped is taken in the idle state.
//   A delta packet steps through accept, delta add, value add and point load,
//   skipping the load when no point is shown; an absolute packet through
//   accept, value load and point load. A repeat packet is accepted, then each
//   shown point is advanced and loaded; only advanced are the points past the
//   sixtieth, or all of them before an anchored track is open.
//   A point is presented on out_* from the cycle after its load.
// Stall: a held point keeps its register; the sequencer waits on the next
//   point, adding the stall cycles, and new bytes are taken while the last
//   point still waits.
// Reset: synchronous, active low; clears values, deltas, flags and the mask
//   to its reset value; no clearing pass is needed.
module track_log_delta_decoder_top import tld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // [0] block_start
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // latitude_ms, longitude_ms, altitude, time_seconds
  output logic [1:0]   out_tuser,  // [0] new_track, [1] new_segment
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data
);

  tld_cmd_t cmd;
  logic     slot_free;

  assign cfg_ready = 1'b1;

  tld_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_byte        (in_tdata),
    .in_block_start (in_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .slot_free      (slot_free),
    .cmd            (cmd)
  );

  tld_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_byte   (in_tdata),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_flags (out_tuser),
    .out_last  (out_tlast)
  );

endmodule
